/* design/bfmd_pkg.sv */
// bfmd_pkg: shared types and constants of the 2x2 box-filter mip downsampler.
// No dependencies; used by box_filter_mip_downsampler, bfmd_checker and tb_top.

package bfmd_pkg;

  // Default for the widest source line the line buffer covers.
  localparam int unsigned MaxWidthDefault = 4096;

  // Source height clamp and the counter widths that follow from it.
  localparam int unsigned HeightLimit = 4096;
  localparam int unsigned HeightW     = $clog2(HeightLimit + 1);  // clamped height
  localparam int unsigned RowW        = $clog2(HeightLimit);      // row counter
  localparam int unsigned OutRowW     = RowW - 1;                 // destination row

  // Register field widths.
  localparam int unsigned DimW   = 13;
  localparam int unsigned ChanW  = 3;
  localparam int unsigned NumChan = 4;

  // APB port.
  localparam int unsigned PaddrW = 4;
  localparam int unsigned PdataW = 32;

  // Register indexes (paddr[3:2]).
  typedef enum logic [1:0] {
    REG_SRC_WIDTH     = 2'd0,
    REG_SRC_HEIGHT    = 2'd1,
    REG_CHANNEL_COUNT = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_e;

  // Reset values.
  localparam logic [DimW-1:0]  SrcWidthReset  = DimW'(1);
  localparam logic [DimW-1:0]  SrcHeightReset = DimW'(1);
  localparam logic [ChanW-1:0] ChanCountReset = ChanW'(4);

  // Pixel and line buffer formats.
  typedef logic [NumChan-1:0][7:0] pix_t;   // one pixel, channel 0 in the low byte
  typedef logic [NumChan-1:0][8:0] psum_t;  // horizontal pair sums, one per channel
  localparam int unsigned LineWordW = $bits(psum_t);

endpackage

/* design/bfmd_ram.sv */
// bfmd_ram: generic single-write, single-read synchronous RAM.
// Read data is registered and only updates on a read enable. No dependencies.

module bfmd_ram #(
  parameter int unsigned Width = 36,
  parameter int unsigned Depth = 2048,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/box_filter_mip_downsampler.sv */
// box_filter_mip_downsampler: one mip level by truncating 2x2 box average.
// Depends on bfmd_pkg (types, constants) and bfmd_ram (pair-sum line buffer).
//
//  Channel   Direction  Handshake                 Payload
//  -------   ---------  ------------------------  ----------------------------------
//  pixel in  input      in_valid_i / in_ready_o   pix_c0_i..pix_c3_i
//  pixel out output     out_valid_o / out_ready_i out_c0_o..out_c3_o, frame_end_o
//  config    input      APB psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// One source pixel per clock while in_ready_o is high. The odd-column request
// that completes a result is registered alongside the line buffer read, then
// moves into the output register. Reset (rst_ni low) returns the registers to
// 1 x 1, four channels, and the position to the first pixel; the line buffer is
// not cleared, since every entry is written on an even row before it is read.
// A stalled output holds the output register, then the read stage, and only
// then drops in_ready_o. Any write to a mapped register restarts the frame.

module box_filter_mip_downsampler #(
  parameter int unsigned MAX_WIDTH = bfmd_pkg::MaxWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  // Pixel input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    pix_c0_i,
  input  logic [7:0]                    pix_c1_i,
  input  logic [7:0]                    pix_c2_i,
  input  logic [7:0]                    pix_c3_i,

  // Pixel output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    out_c0_o,
  output logic [7:0]                    out_c1_o,
  output logic [7:0]                    out_c2_o,
  output logic [7:0]                    out_c3_o,
  output logic                          frame_end_o,

  // APB configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bfmd_pkg::PaddrW-1:0]   paddr,
  input  logic [bfmd_pkg::PdataW-1:0]   pwdata,
  output logic [bfmd_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);

  // Line buffer holds one entry per destination column.
  localparam int unsigned LineDepth = (MAX_WIDTH + 1) / 2;
  localparam int unsigned AddrW     = (LineDepth > 1) ? $clog2(LineDepth) : 1;
  localparam int unsigned ColW      = $clog2(MAX_WIDTH);      // column counter
  localparam int unsigned WidthW    = $clog2(MAX_WIDTH + 1);  // clamped width

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [bfmd_pkg::DimW-1:0]  src_width_q, src_height_q;
  logic [bfmd_pkg::ChanW-1:0] chan_count_q;
  logic                       cfg_wr;
  bfmd_pkg::reg_idx_e         cfg_idx;
  logic                       cfg_hit;

  assign pready  = 1'b1;
  assign cfg_idx = bfmd_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;
  // Writes to an unused address change nothing and do not restart the frame.
  assign cfg_hit = cfg_wr & (cfg_idx != bfmd_pkg::REG_UNUSED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= bfmd_pkg::SrcWidthReset;
      src_height_q <= bfmd_pkg::SrcHeightReset;
      chan_count_q <= bfmd_pkg::ChanCountReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        bfmd_pkg::REG_SRC_WIDTH:     src_width_q  <= pwdata[bfmd_pkg::DimW-1:0];
        bfmd_pkg::REG_SRC_HEIGHT:    src_height_q <= pwdata[bfmd_pkg::DimW-1:0];
        bfmd_pkg::REG_CHANNEL_COUNT: chan_count_q <= pwdata[bfmd_pkg::ChanW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      bfmd_pkg::REG_SRC_WIDTH:     prdata = bfmd_pkg::PdataW'(src_width_q);
      bfmd_pkg::REG_SRC_HEIGHT:    prdata = bfmd_pkg::PdataW'(src_height_q);
      bfmd_pkg::REG_CHANNEL_COUNT: prdata = bfmd_pkg::PdataW'(chan_count_q);
      default:                     prdata = '0;
    endcase
  end

  // Clamped geometry. Zero acts as one, oversize values as the limit.
  logic [WidthW-1:0]            w_eff;
  logic [bfmd_pkg::HeightW-1:0] h_eff;
  logic [bfmd_pkg::ChanW-1:0]   nch_eff;
  logic                         w_one, h_one;
  logic [AddrW-1:0]             dw_m1;
  logic [bfmd_pkg::OutRowW-1:0] dh_m1;

  always_comb begin
    if (src_width_q == '0) begin
      w_eff = WidthW'(1);
    end else if (32'(src_width_q) > MAX_WIDTH) begin
      w_eff = WidthW'(MAX_WIDTH);
    end else begin
      w_eff = WidthW'(src_width_q);
    end

    if (src_height_q == '0) begin
      h_eff = bfmd_pkg::HeightW'(1);
    end else if (32'(src_height_q) > bfmd_pkg::HeightLimit) begin
      h_eff = bfmd_pkg::HeightW'(bfmd_pkg::HeightLimit);
    end else begin
      h_eff = bfmd_pkg::HeightW'(src_height_q);
    end

    if (chan_count_q == '0) begin
      nch_eff = bfmd_pkg::ChanW'(1);
    end else if (chan_count_q > bfmd_pkg::ChanW'(bfmd_pkg::NumChan)) begin
      nch_eff = bfmd_pkg::ChanW'(bfmd_pkg::NumChan);
    end else begin
      nch_eff = chan_count_q;
    end

    w_one = (w_eff == WidthW'(1));
    h_one = (h_eff == bfmd_pkg::HeightW'(1));
    // Last destination column / row index
    dw_m1 = w_one ? '0 : AddrW'((w_eff >> 1) - WidthW'(1));
    dh_m1 = h_one ? '0
                  : bfmd_pkg::OutRowW'((h_eff >> 1) - bfmd_pkg::HeightW'(1));
  end

  // ---------------------------------------------------------------------------
  // Stage 0: position, horizontal pair sum, line buffer access
  // ---------------------------------------------------------------------------
  logic [ColW-1:0]           cx_q, cx_d;
  logic [bfmd_pkg::RowW-1:0] cy_q, cy_d;
  bfmd_pkg::pix_t            held_q, held_d;
  bfmd_pkg::pix_t            pix;
  bfmd_pkg::psum_t           ps;
  logic                      in_acc;
  logic                      hdone, emit, use_line, line_wr;
  logic [AddrW-1:0]          ox;
  logic [bfmd_pkg::OutRowW-1:0] oy;
  logic [1:0]                shift;
  logic                      last_pix;

  assign pix = {pix_c3_i, pix_c2_i, pix_c1_i, pix_c0_i};

  always_comb begin
    // Width of one: each pixel is its own horizontal group.
    hdone = w_one | cx_q[0];
    for (int c = 0; c < bfmd_pkg::NumChan; c++) begin
      ps[c] = w_one ? {1'b0, pix[c]} : ({1'b0, held_q[c]} + {1'b0, pix[c]});
    end
    ox       = w_one ? '0 : AddrW'(cx_q >> 1);
    oy       = h_one ? '0 : cy_q[bfmd_pkg::RowW-1:1];
    use_line = ~h_one & cy_q[0];
    emit     = hdone & (h_one | cy_q[0]);
    // Odd height: the last even row is not stored since it is never paired.
    line_wr  = in_acc & hdone & ~h_one & ~cy_q[0] &
               ((bfmd_pkg::HeightW'(cy_q) + bfmd_pkg::HeightW'(1)) < h_eff);
    shift    = {1'b0, ~w_one} + {1'b0, ~h_one};
    last_pix = (ox == dw_m1) & (oy == dh_m1);

    cx_d   = cx_q;
    cy_d   = cy_q;
    held_d = held_q;
    if (cfg_hit) begin
      cx_d   = '0;
      cy_d   = '0;
      held_d = '0;
    end else if (in_acc) begin
      if (!cx_q[0]) begin
        held_d = pix;
      end
      if ((WidthW'(cx_q) + WidthW'(1)) >= w_eff) begin
        cx_d = '0;
        if ((bfmd_pkg::HeightW'(cy_q) + bfmd_pkg::HeightW'(1)) >= h_eff) begin
          cy_d = '0;
        end else begin
          cy_d = cy_q + bfmd_pkg::RowW'(1);
        end
      end else begin
        cx_d = cx_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q   <= '0;
      cy_q   <= '0;
      held_q <= '0;
    end else begin
      cx_q   <= cx_d;
      cy_q   <= cy_d;
      held_q <= held_d;
    end
  end

  // Pair sums of even rows. Read and write never touch one entry in one
  // cycle: the read of an entry comes a full source row after its write.
  bfmd_pkg::psum_t line_rdata;

  bfmd_ram #(
    .Width (bfmd_pkg::LineWordW),
    .Depth (LineDepth),
    .AddrW (AddrW)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (line_wr),
    .waddr_i (ox),
    .wdata_i (ps),
    .re_i    (in_acc & emit & use_line),
    .raddr_i (ox),
    .rdata_o (line_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: vertical add and scale; output register
  // ---------------------------------------------------------------------------
  logic            s1_valid_q, s1_valid_d;
  bfmd_pkg::psum_t s1_ps_q;
  logic [1:0]      s1_shift_q;
  logic            s1_line_q;
  logic            s1_last_q;
  logic            s1_adv;

  logic            out_valid_q, out_valid_d;
  bfmd_pkg::pix_t  out_pix_q, out_pix_d;
  logic            out_last_q;
  logic [9:0]      vsum;

  assign s1_adv     = ~out_valid_q | out_ready_i;
  assign in_ready_o = ~s1_valid_q | s1_adv;
  assign in_acc     = in_valid_i & in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = emit;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (s1_valid_q && s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // Divisor 1, 2 or 4 as a truncating shift; unused channels read zero.
    for (int c = 0; c < bfmd_pkg::NumChan; c++) begin
      vsum = {1'b0, s1_ps_q[c]} + (s1_line_q ? {1'b0, line_rdata[c]} : 10'd0);
      vsum = vsum >> s1_shift_q;
      out_pix_d[c] = (bfmd_pkg::ChanW'(c) < nch_eff) ? vsum[7:0] : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ps_q    <= ps;
      s1_shift_q <= shift;
      s1_line_q  <= use_line;
      s1_last_q  <= last_pix;
    end
    if (s1_valid_q && s1_adv) begin
      out_pix_q  <= out_pix_d;
      out_last_q <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_c0_o    = out_pix_q[0];
  assign out_c1_o    = out_pix_q[1];
  assign out_c2_o    = out_pix_q[2];
  assign out_c3_o    = out_pix_q[3];
  assign frame_end_o = out_last_q;

endmodule

/* bench/bfmd_checker.sv */
`timescale 1ns / 100ps
// bfmd_checker: watches the pixel, result and APB channels of the mip downsampler,
// predicts each averaged pixel and compares it. Depends on bfmd_pkg.

module bfmd_checker #(
  parameter int unsigned MAX_WIDTH = bfmd_pkg::MaxWidthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [7:0]                  pix_c0_i,
  input  logic [7:0]                  pix_c1_i,
  input  logic [7:0]                  pix_c2_i,
  input  logic [7:0]                  pix_c3_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [7:0]                  out_c0_i,
  input  logic [7:0]                  out_c1_i,
  input  logic [7:0]                  out_c2_i,
  input  logic [7:0]                  out_c3_i,
  input  logic                        frame_end_i,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [bfmd_pkg::PaddrW-1:0] paddr_i,
  input  logic [bfmd_pkg::PdataW-1:0] pwdata_i,
  input  logic [bfmd_pkg::PdataW-1:0] prdata_i,
  input  logic                        pready_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_count_o,
  output int unsigned                 result_count_o
);

  localparam int unsigned LineDepth = (MAX_WIDTH + 1) / 2;

  typedef struct packed {
    bfmd_pkg::pix_t chans;
    logic           last;
  } mip_pixel_t;

  logic [bfmd_pkg::DimW-1:0]  src_width_q;
  logic [bfmd_pkg::DimW-1:0]  src_height_q;
  logic [bfmd_pkg::ChanW-1:0] chan_count_q;
  bfmd_pkg::psum_t            pair_line [LineDepth];
  bfmd_pkg::pix_t             held_q;
  int unsigned                col_q;
  int unsigned                row_q;
  mip_pixel_t                 expected_pixels [$];

  task automatic restart_frame();
    held_q = '0;
    col_q  = 0;
    row_q  = 0;
  endtask

  // One source pixel: horizontal pair, then vertical pair through the line store.
  task automatic downsample_pixel(input bfmd_pkg::pix_t px);
    int unsigned w, h, nch, ox, oy, shift, dw, dh;
    bfmd_pkg::psum_t ps;
    logic [bfmd_pkg::NumChan-1:0][9:0] total;
    bit hdone, emit;
    mip_pixel_t res;
    w = (src_width_q == '0) ? 1 : (src_width_q > MAX_WIDTH) ? MAX_WIDTH : src_width_q;
    h = (src_height_q == '0) ? 1 :
        (src_height_q > bfmd_pkg::HeightLimit) ? bfmd_pkg::HeightLimit : src_height_q;
    nch = (chan_count_q == '0) ? 1 :
          (chan_count_q > bfmd_pkg::NumChan) ? bfmd_pkg::NumChan : chan_count_q;
    hdone = 1'b0;
    emit  = 1'b0;
    ox = 0;
    oy = 0;
    shift = 0;
    ps = '0;
    total = '0;
    if (w == 1) begin
      for (int c = 0; c < bfmd_pkg::NumChan; c++) ps[c] = {1'b0, px[c]};
      hdone = 1'b1;
    end else if (col_q[0]) begin
      for (int c = 0; c < bfmd_pkg::NumChan; c++) ps[c] = {1'b0, held_q[c]} + {1'b0, px[c]};
      hdone = 1'b1;
      ox = col_q >> 1;
    end else if (col_q + 1 < w) begin
      held_q = px;
    end
    if (hdone && ox < LineDepth) begin
      if (h == 1) begin
        for (int c = 0; c < bfmd_pkg::NumChan; c++) total[c] = {1'b0, ps[c]};
        shift = (w == 1) ? 0 : 1;
        emit = 1'b1;
      end else if (row_q[0]) begin
        for (int c = 0; c < bfmd_pkg::NumChan; c++) begin
          total[c] = {1'b0, pair_line[ox][c]} + {1'b0, ps[c]};
        end
        shift = (w == 1) ? 1 : 2;
        oy = row_q >> 1;
        emit = 1'b1;
      end else if (row_q + 1 < h) begin
        pair_line[ox] = ps;
      end
    end
    col_q++;
    if (col_q >= w) begin
      col_q = 0;
      row_q++;
      if (row_q >= h) row_q = 0;
    end
    if (emit) begin
      dw = (w == 1) ? 1 : (w >> 1);
      dh = (h == 1) ? 1 : (h >> 1);
      for (int c = 0; c < bfmd_pkg::NumChan; c++) begin
        res.chans[c] = (c < nch) ? 8'(total[c] >> shift) : 8'h00;
      end
      res.last = (ox == dw - 1) && (oy == dh - 1);
      expected_pixels = {expected_pixels, res};
    end
  endtask

  task automatic check_result(input mip_pixel_t got);
    mip_pixel_t want;
    result_count_o++;
    if (expected_pixels.size() == 0) begin
      $error("mip pixel with nothing expected: chans %h frame_end %b", got.chans, got.last);
      fail_count_o++;
    end else begin
      want = expected_pixels.pop_front();
      for (int c = 0; c < bfmd_pkg::NumChan; c++) begin
        if (got.chans[c] !== want.chans[c]) begin
          $error("out_c%0d: expected %0d, got %0d", c, want.chans[c], got.chans[c]);
          fail_count_o++;
        end
      end
      if (got.last !== want.last) begin
        $error("frame_end: expected %0b, got %0b", want.last, got.last);
        fail_count_o++;
      end
    end
  endtask

  // Everything is sampled at the rising edge, before the edge's updates land.
  always @(posedge clk_i) begin : monitor
    bfmd_pkg::reg_idx_e idx;
    logic [bfmd_pkg::PdataW-1:0] readback;
    bit mapped;
    if (!rst_ni) begin
      src_width_q  = bfmd_pkg::SrcWidthReset;
      src_height_q = bfmd_pkg::SrcHeightReset;
      chan_count_q = bfmd_pkg::ChanCountReset;
      restart_frame();
      expected_pixels.delete();
      fail_count_o   = 0;
      result_count_o = 0;
    end else begin
      idx = bfmd_pkg::reg_idx_e'(paddr_i[bfmd_pkg::PaddrW-1:2]);
      if (psel_i && penable_i && pready_i && pwrite_i) begin
        // any mapped write restarts the frame; the spare slot does nothing
        case (idx)
          bfmd_pkg::REG_SRC_WIDTH: begin
            src_width_q = pwdata_i[bfmd_pkg::DimW-1:0];
            restart_frame();
          end
          bfmd_pkg::REG_SRC_HEIGHT: begin
            src_height_q = pwdata_i[bfmd_pkg::DimW-1:0];
            restart_frame();
          end
          bfmd_pkg::REG_CHANNEL_COUNT: begin
            chan_count_q = pwdata_i[bfmd_pkg::ChanW-1:0];
            restart_frame();
          end
          default: ;
        endcase
      end else if (psel_i && penable_i && pready_i) begin
        mapped = 1'b1;
        case (idx)
          bfmd_pkg::REG_SRC_WIDTH:     readback = bfmd_pkg::PdataW'(src_width_q);
          bfmd_pkg::REG_SRC_HEIGHT:    readback = bfmd_pkg::PdataW'(src_height_q);
          bfmd_pkg::REG_CHANNEL_COUNT: readback = bfmd_pkg::PdataW'(chan_count_q);
          default: begin
            readback = '0;
            mapped = 1'b0;
          end
        endcase
        if (mapped && prdata_i !== readback) begin
          $error("prdata %s: expected %0d, got %0d", idx.name(), readback, prdata_i);
          fail_count_o++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        downsample_pixel({pix_c3_i, pix_c2_i, pix_c1_i, pix_c0_i});
      end
      if (out_valid_i && out_ready_i) begin
        check_result({out_c3_i, out_c2_i, out_c1_i, out_c0_i, frame_end_i});
      end
    end
    pending_count_o = expected_pixels.size();
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: drives pixel requests, APB setup and output back-pressure into the
// mip downsampler; bfmd_checker predicts and compares. Needs bfmd_pkg.

module tb_top;

  localparam int unsigned RandomPixels = 400;
  localparam int unsigned TailPixels   = 120;  // final stretch runs with no idling
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned LongStall    = 200;
  localparam int unsigned WideRowPixels = 64;  // start of a clamped-width row

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  logic [7:0]                  pix_c0_i    = '0;
  logic [7:0]                  pix_c1_i    = '0;
  logic [7:0]                  pix_c2_i    = '0;
  logic [7:0]                  pix_c3_i    = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [7:0]                  out_c0_o;
  logic [7:0]                  out_c1_o;
  logic [7:0]                  out_c2_o;
  logic [7:0]                  out_c3_o;
  logic                        frame_end_o;
  logic                        psel        = 1'b0;
  logic                        penable     = 1'b0;
  logic                        pwrite      = 1'b0;
  logic [bfmd_pkg::PaddrW-1:0] paddr       = '0;
  logic [bfmd_pkg::PdataW-1:0] pwdata      = '0;
  logic [bfmd_pkg::PdataW-1:0] prdata;
  logic                        pready;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned result_count;
  int unsigned pixels_sent = 0;
  int unsigned formats_run = 0;

  // idling switches shared between the request side and the result side
  bit src_idle_on    = 1'b1;
  bit sink_idle_on   = 1'b1;
  bit long_stall_req = 1'b0;

  always #5 clk_i = ~clk_i;

  box_filter_mip_downsampler u_dut (.*);

  bfmd_checker u_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i      (in_ready_o),
    .pix_c0_i,
    .pix_c1_i,
    .pix_c2_i,
    .pix_c3_i,
    .out_valid_i     (out_valid_o),
    .out_ready_i,
    .out_c0_i        (out_c0_o),
    .out_c1_i        (out_c1_o),
    .out_c2_i        (out_c2_o),
    .out_c3_i        (out_c3_o),
    .frame_end_i     (frame_end_o),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_i        (prdata),
    .pready_i        (pready),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count),
    .result_count_o  (result_count)
  );

  // Channel values lean on the extremes so every bit toggles both ways early.
  function automatic bfmd_pkg::pix_t random_pixel();
    bfmd_pkg::pix_t px;
    for (int c = 0; c < bfmd_pkg::NumChan; c++) begin
      case ($urandom_range(0, 7))
        0:       px[c] = 8'h00;
        1:       px[c] = 8'hFF;
        default: px[c] = 8'($urandom());
      endcase
    end
    return px;
  endfunction

  // One pixel request. An optional gap drops valid first; once raised, valid and
  // the payload hold until the block takes the request.
  task automatic send_pixel(input bfmd_pkg::pix_t px);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {pix_c3_i, pix_c2_i, pix_c1_i, pix_c0_i} <= px;
    do @(posedge clk_i); while (!in_ready_o);
    pixels_sent++;
  endtask

  task automatic send_pixels(input int unsigned count);
    repeat (count) send_pixel(random_pixel());
  endtask

  // Sender stops until every predicted pixel has come out. A trailing odd
  // column or row makes no result, so a few more cycles let it finish.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // APB write: setup, access, then idle with psel low. Bits above the field are random
  // and must be ignored by the register.
  task automatic write_reg(input bfmd_pkg::reg_idx_e idx,
                           input logic [bfmd_pkg::PdataW-1:0] value);
    logic [bfmd_pkg::PdataW-1:0] mask;
    mask = (idx == bfmd_pkg::REG_CHANNEL_COUNT) ?
           bfmd_pkg::PdataW'((1 << bfmd_pkg::ChanW) - 1) :
           bfmd_pkg::PdataW'((1 << bfmd_pkg::DimW) - 1);
    if (idx == bfmd_pkg::REG_UNUSED) mask = '0;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= (bfmd_pkg::PdataW'($urandom()) & ~mask) | (value & mask);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // New format, then read back all three registers (checked by the checker).
  task automatic set_format(input int unsigned w, input int unsigned h, input int unsigned ch);
    bfmd_pkg::reg_idx_e readback_order [3] = '{bfmd_pkg::REG_SRC_WIDTH,
                                               bfmd_pkg::REG_SRC_HEIGHT,
                                               bfmd_pkg::REG_CHANNEL_COUNT};
    write_reg(bfmd_pkg::REG_SRC_WIDTH, bfmd_pkg::PdataW'(w));
    write_reg(bfmd_pkg::REG_SRC_HEIGHT, bfmd_pkg::PdataW'(h));
    write_reg(bfmd_pkg::REG_CHANNEL_COUNT, bfmd_pkg::PdataW'(ch));
    foreach (readback_order[i]) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {readback_order[i], 2'b00};
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clk_i);
    end
    formats_run++;
  endtask

  // Result side: random ready bursts, plenty of always-ready stretches, and one
  // long hold-off on request so the pipeline backs up into in_ready_o.
  initial begin : result_sink
    forever begin
      if (long_stall_req) begin
        out_ready_i <= 1'b0;
        repeat (LongStall) @(posedge clk_i);
        long_stall_req = 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int unsigned w, h, ch, ew, eh, frame, count, random_start;
    bit tail;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part ---
    // reset format is 1x1 with four channels: pixels pass straight through
    send_pixel('0);
    send_pixel('1);
    wait_drained();
    // full-scale 2x2 sum still lands on 255 after the divide by four
    set_format(2, 2, 4);
    repeat (4) send_pixel('1);
    wait_drained();
    // odd width and height: last column and last row dropped, two channels live
    set_format(3, 3, 2);
    send_pixels(9);
    wait_drained();
    // a write to the spare slot must not restart the half-done frame
    set_format(2, 2, 1);
    send_pixels(2);
    wait_drained();
    write_reg(bfmd_pkg::REG_UNUSED, bfmd_pkg::PdataW'($urandom()));
    send_pixels(2);
    wait_drained();
    // width of one: vertical pairs only, divide by two
    set_format(1, 2, 3);
    send_pixels(2);
    wait_drained();
    // height of one, zero channel count acting as one
    set_format(2, 1, 0);
    send_pixels(2);
    wait_drained();
    // zero dimensions act as one, channel count above four acts as four
    set_format(0, 0, 7);
    send_pixels(1);
    wait_drained();

    // --- the few large formats ---
    // oversize width clamps to the line buffer limit: only the start of the row
    set_format((1 << bfmd_pkg::DimW) - 1, 1, 4);
    send_pixels(WideRowPixels);
    wait_drained();
    // height clamp: a tall single column, only part of it
    set_format(1, (1 << bfmd_pkg::DimW) - 1, $urandom_range(0, 7));
    send_pixels(40);
    wait_drained();

    // --- back-pressure: every pixel makes a result while the output is held off ---
    set_format(1, 1, 4);
    long_stall_req = 1'b1;
    send_pixels(80);
    wait_drained();

    // --- random formats: mostly whole frames, some cut short ---
    random_start = pixels_sent;
    while (pixels_sent - random_start < RandomPixels) begin
      tail = (pixels_sent - random_start >= RandomPixels - TailPixels);
      src_idle_on  = !tail && ($urandom_range(0, 3) != 0);
      sink_idle_on = !tail && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0:       w = 0;
        1:       w = $urandom_range(17, 64);
        default: w = $urandom_range(1, 16);
      endcase
      case ($urandom_range(0, 9))
        0:       h = 0;
        1:       h = $urandom_range(7, 10);
        default: h = $urandom_range(1, 6);
      endcase
      ch = $urandom_range(0, 7);
      set_format(w, h, ch);
      ew = (w == 0) ? 1 : w;
      eh = (h == 0) ? 1 : h;
      frame = ew * eh;
      count = frame * $urandom_range(1, 2);
      // broken sequence: stop partway into a frame, next write restarts it
      if (frame > 1 && $urandom_range(0, 4) == 0) count += $urandom_range(1, frame - 1);
      send_pixels(count);
      wait_drained();
    end

    $display("Covered %0d source pixels over %0d formats; %0d averaged pixels checked.",
             pixels_sent, formats_run, result_count);
    $display("Included zero and clamped sizes, odd edges, all channel counts, long stall.");
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
